// File: sv/psg_pkg.sv
package psg_pkg;

   localparam int unsigned SubsampleScaleDefault = 32768;

   localparam logic [15:0] StepReset     = 16'd11303;
   localparam logic [31:0] TonePerReset  = 32'd11303;
   localparam logic [31:0] NoisePerReset = 32'd226060;
   localparam logic [31:0] EnvPerReset   = 32'd5651;

   localparam int CounterWidth = 36;
   localparam int DutyWidth    = 40;

   localparam logic [3:0] RegToneLast   = 4'd5;
   localparam logic [3:0] RegNoise      = 4'd6;
   localparam logic [3:0] RegEnable     = 4'd7;
   localparam logic [3:0] RegAmpA       = 4'd8;
   localparam logic [3:0] RegAmpC       = 4'd10;
   localparam logic [3:0] RegEnvFine    = 4'd11;
   localparam logic [3:0] RegEnvCoarse  = 4'd12;
   localparam logic [3:0] RegShape      = 4'd13;
   localparam logic [7:0] EnableReset   = 8'h38;

   localparam logic [2:0] SlotNoise = 3'd3;
   localparam logic [2:0] SlotEnv   = 3'd4;

   localparam logic [17:0] NoiseTap = 18'h28000;

   typedef enum logic [1:0] {
      BUS_IDLE  = 2'd0,
      BUS_READ  = 2'd1,
      BUS_WRITE = 2'd2,
      BUS_LATCH = 2'd3
   } bus_mode_type;

   typedef enum logic {
      OP_BUS    = 1'b0,
      OP_SAMPLE = 1'b1
   } operation_type;

endpackage

// File: sv/psg_channels.sv
interface psg_req_if;
   import psg_pkg::*;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [1:0] bus_mode;
   logic [7:0] bus_data;
   modport source (output valid, operation, bus_mode, bus_data, input ready);
   modport sink (input valid, operation, bus_mode, bus_data, output ready);
endinterface

interface psg_rsp_if;
   import psg_pkg::*;
   logic        valid;
   logic        ready;
   logic [7:0]  read_data;
   logic [15:0] duty_a;
   logic [15:0] duty_b;
   logic [15:0] duty_c;
   logic [4:0]  level_a;
   logic [4:0]  level_b;
   logic [4:0]  level_c;
   modport source (output valid, read_data, duty_a, duty_b, duty_c, level_a, level_b,
                   level_c, input ready);
   modport sink (input valid, read_data, duty_a, duty_b, duty_c, level_a, level_b,
                 level_c, output ready);
endinterface

// File: sv/psg_mult.sv
module psg_mult
   import psg_pkg::*;
(
   input  logic        clock,
   input  logic [15:0] factor_a,
   input  logic [15:0] factor_b,
   output logic [31:0] product_ff
);

   logic [31:0] product_in;

   assign product_in = factor_a * factor_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

// File: sv/psg_tone_noise_envelope_core.sv
// bus beat: idle then done; period write: multiply, select, update, add, done
// sample beat: pre pass, tone and noise loops per noise event, then envelope steps
// all loops step through the one sequencer, one item at a time
// a result waits in the output register while the next beat is taken
// reset is synchronous: registers to zero but enable 0x38, periods from step 11303
module psg_tone_noise_envelope_core
   import psg_pkg::*;
#(
   parameter int unsigned SUBSAMPLE_SCALE = SubsampleScaleDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   psg_req_if.sink     req_chan,
   psg_rsp_if.source   rsp_chan
);

   localparam logic signed [CounterWidth-1:0] ScaleW = CounterWidth'(SUBSAMPLE_SCALE);
   localparam logic signed [17:0]             ScaleL = 18'(SUBSAMPLE_SCALE);

   typedef enum logic [19:0] {
      ST_IDLE     = 20'h00001,
      ST_RT_MUL   = 20'h00002,
      ST_RT_SEL   = 20'h00004,
      ST_RT_UPD   = 20'h00008,
      ST_RT_ADD   = 20'h00010,
      ST_PRE      = 20'h00020,
      ST_EV       = 20'h00040,
      ST_TA_START = 20'h00080,
      ST_TA_LOOP  = 20'h00100,
      ST_TA_FLIP  = 20'h00200,
      ST_TA_END   = 20'h00400,
      ST_NOISE    = 20'h00800,
      ST_NCHK     = 20'h01000,
      ST_ENV      = 20'h02000,
      ST_ENV_CHK0 = 20'h04000,
      ST_ENV_DEC  = 20'h08000,
      ST_ENV_CHK1 = 20'h10000,
      ST_ENV_WRAP = 20'h20000,
      ST_DONE     = 20'h40000
   } state_type;

   typedef logic signed [CounterWidth-1:0] cnt_type;
   typedef logic signed [DutyWidth-1:0]    duty_type;

   state_type   state_ff, state_in;
   logic [2:0]  idx_ff, idx_in;
   logic [15:0] step_ff, step_in;
   logic [7:0]  rf_ff [16];
   logic [7:0]  rf_in [16];
   logic [7:0]  addr_ff, addr_in;
   logic [31:0] per_ff [5];
   logic [31:0] per_in [5];
   cnt_type     dc_ff [5];
   cnt_type     dc_in [5];
   logic [2:0]  lvl_ff, lvl_in;
   logic        nl_ff, nl_in;
   logic [16:0] sh_ff, sh_in;
   logic [7:0]  pos_ff, pos_in;
   logic        att_ff, att_in, hold_ff, hold_in, alt_ff, alt_in, holding_ff, holding_in;
   logic [4:0]  vl_ff [4];
   logic [4:0]  vl_in [4];
   logic [2:0]  sel_ff, sel_in;
   logic [2:0]  acc_ff, acc_in;
   duty_type    duty_ff [3];
   duty_type    duty_in [3];
   logic signed [17:0] left_ff, left_in, ev_ff, ev_in;
   logic [31:0] np_ff, np_in;
   cnt_type     diff_ff, diff_in;
   logic        resc_ff, resc_in;
   logic        bus_ff, bus_in;
   logic [7:0]  rdata_ff, rdata_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  o_rdata_ff, o_rdata_in;
   logic [15:0] o_duty_ff [3];
   logic [15:0] o_duty_in [3];
   logic [4:0]  o_lvl_ff [3];
   logic [4:0]  o_lvl_in [3];

   logic [15:0] mul_op;
   logic [31:0] product;
   logic [31:0] alt_val;
   logic        req_fire;
   logic [7:0]  en;

   psg_mult u_mult (
      .clock      (clock),
      .factor_a   (mul_op),
      .factor_b   (step_ff),
      .product_ff (product)
   );

   assign en = rf_ff[RegEnable];
   assign req_chan.ready = (state_ff == ST_IDLE) && !csr_write_enable;
   assign req_fire = req_chan.valid && req_chan.ready;

   always_comb begin
      unique case (idx_ff)
         3'd0: mul_op = {4'b0, rf_ff[1][3:0], rf_ff[0]};
         3'd1: mul_op = {4'b0, rf_ff[3][3:0], rf_ff[2]};
         3'd2: mul_op = {4'b0, rf_ff[5][3:0], rf_ff[4]};
         3'd3: mul_op = {11'b0, rf_ff[RegNoise][4:0]};
         default: mul_op = {rf_ff[RegEnvCoarse], rf_ff[RegEnvFine]};
      endcase
      priority if (idx_ff < SlotNoise) begin
         alt_val = {16'b0, step_ff};
      end else if (idx_ff == SlotNoise) begin
         alt_val = {11'b0, step_ff, 5'b0};
      end else if (step_ff[15:1] == 15'd0) begin
         alt_val = 32'd1;
      end else begin
         alt_val = {17'b0, step_ff[15:1]};
      end
   end

   always_comb begin
      logic [3:0]  a;
      logic [4:0]  r;
      logic [3:0]  s;
      logic        fa, fh, fl;
      cnt_type     t;
      logic        cond;
      logic [17:0] tap;
      logic [7:0]  p;
      logic        na;
      duty_type    d;

      state_in = state_ff;
      idx_in = idx_ff;
      step_in = step_ff;
      rf_in = rf_ff;
      addr_in = addr_ff;
      per_in = per_ff;
      dc_in = dc_ff;
      lvl_in = lvl_ff;
      nl_in = nl_ff;
      sh_in = sh_ff;
      pos_in = pos_ff;
      att_in = att_ff;
      hold_in = hold_ff;
      alt_in = alt_ff;
      holding_in = holding_ff;
      vl_in = vl_ff;
      sel_in = sel_ff;
      acc_in = acc_ff;
      duty_in = duty_ff;
      left_in = left_ff;
      ev_in = ev_ff;
      np_in = np_ff;
      diff_in = diff_ff;
      resc_in = resc_ff;
      bus_in = bus_ff;
      rdata_in = rdata_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      o_rdata_in = o_rdata_ff;
      o_duty_in = o_duty_ff;
      o_lvl_in = o_lvl_ff;
      a = addr_ff[3:0];
      r = req_chan.bus_data[4:0];
      s = req_chan.bus_data[3:0];
      fa = 1'b0;
      fh = 1'b0;
      fl = 1'b0;
      t = '0;
      cond = 1'b0;
      tap = '0;
      p = '0;
      na = 1'b0;
      d = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_write_enable) begin
               step_in = (csr_write_data == 16'd0) ? 16'd1 : csr_write_data;
               for (int k = 0; k < 5; k++) begin
                  dc_in[k] = CounterWidth'(1);
               end
               idx_in = 3'd0;
               resc_in = 1'b1;
               state_in = ST_RT_MUL;
            end else if (req_fire) begin
               if (req_chan.operation == OP_SAMPLE) begin
                  bus_in = 1'b0;
                  rdata_in = 8'd0;
                  for (int k = 0; k < 3; k++) begin
                     duty_in[k] = '0;
                  end
                  idx_in = 3'd0;
                  left_in = ScaleL;
                  state_in = ST_PRE;
               end else begin
                  bus_in = 1'b1;
                  rdata_in = 8'd0;
                  resc_in = 1'b0;
                  state_in = ST_DONE;
                  unique case (req_chan.bus_mode)
                     BUS_READ: begin
                        if (addr_ff[7:4] == 4'd0) begin
                           rdata_in = rf_ff[a];
                        end
                     end
                     BUS_WRITE: begin
                        if (addr_ff[7:4] == 4'd0) begin
                           rf_in[a] = req_chan.bus_data;
                           priority if (a <= RegToneLast) begin
                              rf_in[{a[3:1], 1'b1}] = {4'b0, rf_in[{a[3:1], 1'b1}][3:0]};
                              idx_in = {1'b0, a[2:1]};
                              state_in = ST_RT_MUL;
                           end else if (a == RegNoise) begin
                              rf_in[a] = {3'b0, r};
                              idx_in = SlotNoise;
                              state_in = ST_RT_MUL;
                           end else if (a >= RegAmpA && a <= RegAmpC) begin
                              rf_in[a] = {3'b0, r};
                              sel_in[2'(a - RegAmpA)] = r[4];
                              vl_in[2'(a - RegAmpA)] = (r == 5'd0) ? 5'd0 : {r[3:0], 1'b1};
                           end else if (a == RegEnvFine || a == RegEnvCoarse) begin
                              idx_in = SlotEnv;
                              state_in = ST_RT_MUL;
                           end else if (a == RegShape) begin
                              rf_in[a] = {4'b0, s};
                              fa = s[2];
                              if (!s[3]) begin
                                 fh = 1'b1;
                                 fl = fa;
                              end else begin
                                 fh = s[0];
                                 fl = s[1];
                              end
                              att_in = fa;
                              hold_in = fh;
                              alt_in = fl;
                              holding_in = 1'b0;
                              dc_in[SlotEnv] = CounterWidth'(per_ff[SlotEnv]);
                              pos_in = 8'h1f;
                              vl_in[3] = fa ? 5'd0 : 5'h1f;
                           end else begin
                              rf_in[a] = req_chan.bus_data;
                           end
                        end
                     end
                     BUS_LATCH: begin
                        addr_in = req_chan.bus_data;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         ST_RT_MUL: begin
            state_in = ST_RT_SEL;
         end
         ST_RT_SEL: begin
            np_in = (product == 32'd0) ? alt_val : product;
            state_in = ST_RT_UPD;
         end
         ST_RT_UPD: begin
            per_in[idx_ff] = np_ff;
            if (resc_ff) begin
               if (idx_ff == SlotEnv) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
                  state_in = ST_RT_MUL;
               end
            end else begin
               diff_in = CounterWidth'(np_ff) - CounterWidth'(per_ff[idx_ff]);
               state_in = ST_RT_ADD;
            end
         end
         ST_RT_ADD: begin
            t = dc_ff[idx_ff] + diff_ff;
            dc_in[idx_ff] = (t <= 0) ? CounterWidth'(1) : t;
            state_in = ST_DONE;
         end
         ST_PRE: begin
            if (idx_ff == SlotNoise) begin
               cond = (en[5:3] == 3'b111);
               for (int k = 0; k < 3; k++) begin
                  acc_in[k] = nl_ff | en[3+k];
               end
               state_in = ST_EV;
            end else begin
               cond = en[idx_ff] || (rf_ff[RegAmpA + 4'(idx_ff)] == 8'd0);
               if (en[idx_ff]) begin
                  lvl_in[idx_ff[1:0]] = 1'b1;
               end
               idx_in = idx_ff + 3'd1;
            end
            if (cond && dc_ff[idx_ff] <= ScaleW) begin
               dc_in[idx_ff] = dc_ff[idx_ff] + ScaleW;
            end
         end
         ST_EV: begin
            ev_in = (dc_ff[SlotNoise] < CounterWidth'(left_ff)) ? dc_ff[SlotNoise][17:0]
                                                                 : left_ff;
            idx_in = 3'd0;
            state_in = ST_TA_START;
         end
         ST_TA_START: begin
            if (acc_ff[idx_ff[1:0]] && lvl_ff[idx_ff[1:0]]) begin
               duty_in[idx_ff[1:0]] = duty_ff[idx_ff[1:0]] + DutyWidth'(dc_ff[idx_ff]);
            end
            dc_in[idx_ff] = dc_ff[idx_ff] - CounterWidth'(ev_ff);
            state_in = ST_TA_LOOP;
         end
         ST_TA_LOOP: begin
            if (dc_ff[idx_ff] <= 0) begin
               dc_in[idx_ff] = dc_ff[idx_ff] + CounterWidth'(per_ff[idx_ff]);
               state_in = ST_TA_FLIP;
            end else begin
               state_in = ST_TA_END;
            end
         end
         ST_TA_FLIP: begin
            if (dc_ff[idx_ff] > 0) begin
               lvl_in[idx_ff[1:0]] = !lvl_ff[idx_ff[1:0]];
               if (acc_ff[idx_ff[1:0]] && !lvl_ff[idx_ff[1:0]]) begin
                  duty_in[idx_ff[1:0]] = duty_ff[idx_ff[1:0]] + DutyWidth'(per_ff[idx_ff]);
               end
               state_in = ST_TA_END;
            end else begin
               dc_in[idx_ff] = dc_ff[idx_ff] + CounterWidth'(per_ff[idx_ff]);
               if (acc_ff[idx_ff[1:0]]) begin
                  duty_in[idx_ff[1:0]] = duty_ff[idx_ff[1:0]] + DutyWidth'(per_ff[idx_ff]);
               end
               state_in = ST_TA_LOOP;
            end
         end
         ST_TA_END: begin
            if (acc_ff[idx_ff[1:0]] && lvl_ff[idx_ff[1:0]]) begin
               duty_in[idx_ff[1:0]] = duty_ff[idx_ff[1:0]] - DutyWidth'(dc_ff[idx_ff]);
            end
            if (idx_ff == 3'd2) begin
               state_in = ST_NOISE;
            end else begin
               idx_in = idx_ff + 3'd1;
               state_in = ST_TA_START;
            end
         end
         ST_NOISE: begin
            dc_in[SlotNoise] = dc_ff[SlotNoise] - CounterWidth'(ev_ff);
            left_in = left_ff - ev_ff;
            state_in = ST_NCHK;
         end
         ST_NCHK: begin
            if (dc_ff[SlotNoise] <= 0) begin
               na = nl_ff;
               if (sh_ff[1] ^ sh_ff[0]) begin
                  na = !nl_ff;
               end
               nl_in = na;
               for (int k = 0; k < 3; k++) begin
                  acc_in[k] = na | en[3+k];
               end
               tap = {1'b0, sh_ff} ^ (sh_ff[0] ? NoiseTap : 18'd0);
               sh_in = tap[17:1];
               dc_in[SlotNoise] = dc_ff[SlotNoise] + CounterWidth'(per_ff[SlotNoise]);
            end
            state_in = (left_ff > 0) ? ST_EV : ST_ENV;
         end
         ST_ENV: begin
            if (holding_ff) begin
               state_in = ST_DONE;
            end else begin
               dc_in[SlotEnv] = dc_ff[SlotEnv] - ScaleW;
               state_in = ST_ENV_CHK0;
            end
         end
         ST_ENV_CHK0: begin
            state_in = (dc_ff[SlotEnv] > 0) ? ST_DONE : ST_ENV_DEC;
         end
         ST_ENV_DEC: begin
            pos_in = pos_ff - 8'd1;
            dc_in[SlotEnv] = dc_ff[SlotEnv] + CounterWidth'(per_ff[SlotEnv]);
            state_in = ST_ENV_CHK1;
         end
         ST_ENV_CHK1: begin
            state_in = (dc_ff[SlotEnv] <= 0) ? ST_ENV_DEC : ST_ENV_WRAP;
         end
         ST_ENV_WRAP: begin
            p = pos_ff;
            fa = att_ff;
            if (pos_ff[7]) begin
               if (hold_ff) begin
                  if (alt_ff) begin
                     fa = !att_ff;
                  end
                  holding_in = 1'b1;
                  p = 8'd0;
               end else begin
                  if (alt_ff && pos_ff[5]) begin
                     fa = !att_ff;
                  end
                  p = {3'b0, pos_ff[4:0]};
               end
            end
            att_in = fa;
            pos_in = p;
            vl_in[3] = p[4:0] ^ (fa ? 5'h1f : 5'h00);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               o_rdata_in = rdata_ff;
               for (int k = 0; k < 3; k++) begin
                  d = duty_ff[k];
                  if (bus_ff || d < 0) begin
                     o_duty_in[k] = 16'd0;
                  end else if (d > DutyWidth'(16'hffff)) begin
                     o_duty_in[k] = 16'hffff;
                  end else begin
                     o_duty_in[k] = d[15:0];
                  end
                  o_lvl_in[k] = bus_ff ? 5'd0 : (sel_ff[k] ? vl_ff[3] : vl_ff[k]);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= 3'd0;
         step_ff <= StepReset;
         for (int k = 0; k < 16; k++) begin
            rf_ff[k] <= 8'd0;
         end
         rf_ff[RegEnable] <= EnableReset;
         addr_ff <= 8'd0;
         for (int k = 0; k < 3; k++) begin
            per_ff[k] <= TonePerReset;
         end
         per_ff[SlotNoise] <= NoisePerReset;
         per_ff[SlotEnv] <= EnvPerReset;
         for (int k = 0; k < 5; k++) begin
            dc_ff[k] <= CounterWidth'(1);
         end
         lvl_ff <= 3'd0;
         nl_ff <= 1'b0;
         sh_ff <= 17'd1;
         pos_ff <= 8'd0;
         att_ff <= 1'b0;
         hold_ff <= 1'b0;
         alt_ff <= 1'b0;
         holding_ff <= 1'b0;
         for (int k = 0; k < 4; k++) begin
            vl_ff[k] <= 5'd0;
         end
         sel_ff <= 3'd0;
         resc_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         step_ff <= step_in;
         rf_ff <= rf_in;
         addr_ff <= addr_in;
         per_ff <= per_in;
         dc_ff <= dc_in;
         lvl_ff <= lvl_in;
         nl_ff <= nl_in;
         sh_ff <= sh_in;
         pos_ff <= pos_in;
         att_ff <= att_in;
         hold_ff <= hold_in;
         alt_ff <= alt_in;
         holding_ff <= holding_in;
         vl_ff <= vl_in;
         sel_ff <= sel_in;
         resc_ff <= resc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      duty_ff <= duty_in;
      left_ff <= left_in;
      ev_ff <= ev_in;
      np_ff <= np_in;
      diff_ff <= diff_in;
      bus_ff <= bus_in;
      rdata_ff <= rdata_in;
      o_rdata_ff <= o_rdata_in;
      o_duty_ff <= o_duty_in;
      o_lvl_ff <= o_lvl_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.read_data = o_rdata_ff;
   assign rsp_chan.duty_a = o_duty_ff[0];
   assign rsp_chan.duty_b = o_duty_ff[1];
   assign rsp_chan.duty_c = o_duty_ff[2];
   assign rsp_chan.level_a = o_lvl_ff[0];
   assign rsp_chan.level_b = o_lvl_ff[1];
   assign rsp_chan.level_c = o_lvl_ff[2];

   // every down counter is positive between beats
   a_counters_positive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (dc_ff[0] > 0 && dc_ff[1] > 0 && dc_ff[2] > 0 &&
                                 dc_ff[3] > 0 && dc_ff[4] > 0))
      else $error("down counter not positive while idle");

   a_periods_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (per_ff[0] != 0 && per_ff[1] != 0 && per_ff[2] != 0 &&
                                 per_ff[3] != 0 && per_ff[4] != 0))
      else $error("zero period while idle");

   a_holding_pos: assert property (@(posedge clock) disable iff (reset)
      holding_ff |-> (pos_ff == 8'd0))
      else $error("envelope holding away from position zero");

   a_step_reload: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && csr_write_enable) |=>
         (dc_ff[0] == 1 && dc_ff[3] == 1 && dc_ff[4] == 1 && step_ff != 16'd0))
      else $error("step write did not reload counters");

endmodule
